// ===== rtl/core/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants for the compacted list table: opcodes, result
// status codes, sequencer states and the control bundle sent to each cell.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int VAL_W = 32;
  localparam int OP_W  = 2;
  localparam int STS_W = 2;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2
  } opcode_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_MISS = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CMP   = 2'd1,
    S_APPLY = 2'd2,
    S_OUT   = 2'd3
  } fsm_t;

  typedef struct packed {
    logic cmp_en;
    logic load_en;
    logic shift_en;
  } cell_ctl_t;

endpackage

// ===== rtl/core/clt_cell.sv =====
// ----------------------------------------------------------------------------
// clt_cell
// One table slot: holds a value, loads the broadcast key on insert, compares
// it with the key, passes the hit flag up and takes the upper value on remove.
// ----------------------------------------------------------------------------
module clt_cell (
  input  logic                              clk,
  input  clt_pkg::cell_ctl_t                ctl,
  input  logic signed [clt_pkg::VAL_W-1:0]  key,
  input  logic                              occupied,
  input  logic                              load_sel,
  input  logic                              hit_in,
  input  logic signed [clt_pkg::VAL_W-1:0]  next_data,
  output logic signed [clt_pkg::VAL_W-1:0]  data,
  output logic                              hit_out,
  output logic                              first
);

  logic signed [clt_pkg::VAL_W-1:0] data_r;
  logic                             match_r;

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      match_r <= occupied && (data_r == key);
    end
    if (ctl.load_en && load_sel) begin
      data_r <= key;
    end else if (ctl.shift_en && (hit_in || match_r)) begin
      // removed slot and everything above it move down by one
      data_r <= next_data;
    end
  end

  assign data    = data_r;
  assign hit_out = hit_in | match_r;
  assign first   = match_r & ~hit_in;

endmodule

// ===== rtl/core/compacted_list_table_core.sv =====
// ----------------------------------------------------------------------------
// compacted_list_table_core
// Compact unsorted list of signed values kept in a chain of slot cells,
// with insert at the fill level, remove of the first match with shift-down,
// and find of the first match.
// ----------------------------------------------------------------------------
// result valid in S_OUT, after the compare (S_CMP) and update (S_APPLY) states
// a new item is accepted only in idle, after the previous result is taken
// the first-match flag ripples through the cell chain in the update cycle
// reset (synchronous, rst_n low): list empty, capacity 16, no result pending
// slot contents are not cleared by reset
module compacted_list_table_core #(
  parameter int DEPTH = clt_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [clt_pkg::OP_W-1:0]          in_opcode,
  input  logic signed [clt_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [clt_pkg::STS_W-1:0]         out_status,
  output logic [clt_pkg::IDX_W-1:0]         out_index,
  output logic [clt_pkg::CNT_W-1:0]         out_fill_count,
  input  logic                              cfg_wr_en,
  input  logic [clt_pkg::CAP_W-1:0]         cfg_wr_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  clt_pkg::fsm_t                    state_r, state_nxt;
  clt_pkg::opcode_t                 op_r;
  logic signed [clt_pkg::VAL_W-1:0] val_r;
  logic [clt_pkg::CAP_W-1:0]        cap_r;
  logic [FW-1:0]                    fill_r, fill_nxt;
  clt_pkg::status_t                 status_r, status_nxt;
  logic [IW-1:0]                    index_r, index_nxt;

  clt_pkg::cell_ctl_t               cell_ctl;
  logic                             do_load, do_shift;
  logic [FW-1:0]                    usable;
  logic [FW-1:0]                    cfg_usable;
  logic [DEPTH:0]                   hit_chain;
  logic [DEPTH-1:0]                 first_vec;
  logic [IW-1:0]                    first_idx;
  logic signed [clt_pkg::VAL_W-1:0] data_vec [DEPTH];

  function automatic logic [FW-1:0] cap_limit(input logic [clt_pkg::CAP_W-1:0] c);
    logic [FW-1:0] lim;
    if (int'(c) > DEPTH) begin
      lim = FW'(DEPTH);
    end else begin
      lim = FW'(c);
    end
    return lim;
  endfunction

  assign usable     = cap_limit(cap_r);
  assign cfg_usable = cap_limit(cfg_wr_data);

  // cell chain
  assign hit_chain[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [clt_pkg::VAL_W-1:0] nbr;
    if (g == DEPTH - 1) begin : g_top
      assign nbr = data_vec[g];
    end else begin : g_mid
      assign nbr = data_vec[g+1];
    end

    clt_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .key       (val_r),
      .occupied  (g < int'(fill_r)),
      .load_sel  (g == int'(fill_r)),
      .hit_in    (hit_chain[g]),
      .next_data (nbr),
      .data      (data_vec[g]),
      .hit_out   (hit_chain[g+1]),
      .first     (first_vec[g])
    );
  end

  always_comb begin
    first_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_vec[i]) begin
        first_idx = first_idx | IW'(i);
      end
    end
  end

  // operation result, used in the update cycle
  always_comb begin
    status_nxt = clt_pkg::STS_MISS;
    index_nxt  = '0;
    fill_nxt   = fill_r;
    do_load    = 1'b0;
    do_shift   = 1'b0;
    case (op_r)
      clt_pkg::OP_INSERT: begin
        if (fill_r < usable) begin
          status_nxt = clt_pkg::STS_OK;
          index_nxt  = IW'(fill_r);
          fill_nxt   = FW'(fill_r + 1'b1);
          do_load    = 1'b1;
        end else begin
          status_nxt = clt_pkg::STS_FULL;
        end
      end
      clt_pkg::OP_REMOVE: begin
        if (hit_chain[DEPTH]) begin
          status_nxt = clt_pkg::STS_OK;
          index_nxt  = first_idx;
          fill_nxt   = FW'(fill_r - 1'b1);
          do_shift   = 1'b1;
        end
      end
      clt_pkg::OP_FIND: begin
        if (hit_chain[DEPTH]) begin
          status_nxt = clt_pkg::STS_OK;
          index_nxt  = first_idx;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      clt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = clt_pkg::S_CMP;
        end
      end
      clt_pkg::S_CMP: begin
        state_nxt = clt_pkg::S_APPLY;
      end
      clt_pkg::S_APPLY: begin
        state_nxt = clt_pkg::S_OUT;
      end
      clt_pkg::S_OUT: begin
        if (out_ready) begin
          state_nxt = clt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = clt_pkg::S_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready          = 1'b0;
    out_valid         = 1'b0;
    cell_ctl          = '0;
    case (state_r)
      clt_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      clt_pkg::S_CMP: begin
        cell_ctl.cmp_en = 1'b1;
      end
      clt_pkg::S_APPLY: begin
        cell_ctl.load_en  = do_load;
        cell_ctl.shift_en = do_shift;
      end
      clt_pkg::S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clt_pkg::S_IDLE;
      cap_r   <= clt_pkg::CAP_RESET;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
        if (fill_r > cfg_usable) begin
          fill_r <= cfg_usable;
        end
      end else if (state_r == clt_pkg::S_APPLY) begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r  <= clt_pkg::opcode_t'(in_opcode);
      val_r <= in_value;
    end
    if (state_r == clt_pkg::S_APPLY) begin
      status_r <= status_nxt;
      index_r  <= index_nxt;
    end
  end

  assign out_status     = status_r;
  assign out_index      = clt_pkg::IDX_W'(index_r);
  assign out_fill_count = clt_pkg::CNT_W'(fill_r);

`ifndef SYNTH
  a_fill_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= usable)
    else $error("fill level above usable capacity");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  // match flags are only meaningful once the compare cycle has run
  a_single_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clt_pkg::S_APPLY) |-> $onehot0(first_vec))
    else $error("more than one first-match cell");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clt_pkg::S_APPLY && op_r == clt_pkg::OP_INSERT &&
     status_nxt == clt_pkg::STS_OK) |=> fill_r == FW'($past(fill_r) + 1'b1))
    else $error("insert did not grow the fill level");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clt_pkg::S_APPLY && op_r == clt_pkg::OP_REMOVE &&
     status_nxt == clt_pkg::STS_OK) |=> fill_r == FW'($past(fill_r) - 1'b1))
    else $error("remove did not shrink the fill level");
`endif

endmodule
